// File: rtl/core/gacc_pkg.sv
// ----------------------------------------------------------------------------
// gacc_pkg
// Shared types, constants and codes of the GHASH accumulator core.
// ----------------------------------------------------------------------------
package gacc_pkg;

  localparam int unsigned HalfW    = 64;
  localparam int unsigned BlockW   = 2 * HalfW;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BlockBytes = BlockW / ByteW;
  localparam int unsigned FillW    = $clog2(BlockBytes);
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 2;

  // Multiplier: one digit of the multiplicand per cycle.
  localparam int unsigned MulDigit = 8;
  localparam int unsigned MulSteps = BlockW / MulDigit;
  localparam int unsigned CntW     = $clog2(MulSteps);
  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);

  // Reduction constant, XORed into the top byte of V.
  localparam logic [ByteW-1:0] RedConst = 8'hE1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 2'd1;

  typedef enum logic [CmdW-1:0] {
    CMD_ABSORB   = 2'd0,
    CMD_PAD      = 2'd1,
    CMD_FINALIZE = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic absorb;
    logic clear;
    logic mul_start;
    logic mul_step;
    logic mul_last;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fill_zero;
    logic fill_last;
  } dp_status_t;

endpackage

// File: rtl/core/gacc_in_if.sv
// ----------------------------------------------------------------------------
// gacc_in_if
// Request channel: command and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface gacc_in_if;
  logic                         valid;
  logic                         ready;
  gacc_pkg::cmd_e               cmd;
  logic [gacc_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

// File: rtl/core/gacc_out_if.sv
// ----------------------------------------------------------------------------
// gacc_out_if
// Result channel: 128-bit hash as two 64-bit halves with valid/ready.
// ----------------------------------------------------------------------------
interface gacc_out_if;
  logic                        valid;
  logic                        ready;
  logic [gacc_pkg::HalfW-1:0]  hash_high;
  logic [gacc_pkg::HalfW-1:0]  hash_low;

  modport source (output valid, hash_high, hash_low, input ready);
  modport sink   (input valid, hash_high, hash_low, output ready);
endinterface

// File: rtl/core/gacc_cfg_if.sv
// ----------------------------------------------------------------------------
// gacc_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface gacc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gacc_pkg::CfgIdxW-1:0]  index;
  logic [gacc_pkg::HalfW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/gacc_datapath.sv
// ----------------------------------------------------------------------------
// gacc_datapath
// Key registers, accumulator, fill count, digit-serial GF(2^128) multiplier
// and result register.
// ----------------------------------------------------------------------------
module gacc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gacc_pkg::dp_cmd_t             cmd_i,
  output gacc_pkg::dp_status_t          status_o,
  input  logic [gacc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          cfg_we_i,
  input  logic [gacc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gacc_pkg::HalfW-1:0]    cfg_data_i,
  output logic [gacc_pkg::HalfW-1:0]    hash_high_o,
  output logic [gacc_pkg::HalfW-1:0]    hash_low_o
);

  logic [gacc_pkg::HalfW-1:0]  key_hi_q, key_hi_d, key_lo_q, key_lo_d;
  logic [gacc_pkg::BlockW-1:0] acc_q, acc_d, acc_abs;
  logic [gacc_pkg::FillW-1:0]  fill_q, fill_d;
  logic [gacc_pkg::BlockW-1:0] x_q, x_d, v_q, v_d, z_q, z_d;
  logic [gacc_pkg::BlockW-1:0] x_nxt, v_nxt, z_nxt;
  logic [gacc_pkg::BlockW-1:0] out_q, out_d;

  // Key register decode; writes beyond the list are dropped.
  always_comb begin
    key_hi_d = key_hi_q;
    key_lo_d = key_lo_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        gacc_pkg::REG_KEY_HIGH: key_hi_d = cfg_data_i;
        gacc_pkg::REG_KEY_LOW:  key_lo_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // XOR the byte in at the current fill position, byte 0 in the top bits.
  always_comb begin
    acc_abs = acc_q;
    for (int b = 0; b < gacc_pkg::BlockBytes; b++) begin
      if (fill_q == gacc_pkg::FillW'(b)) begin
        acc_abs[gacc_pkg::BlockW-1-gacc_pkg::ByteW*b -: gacc_pkg::ByteW] =
          acc_q[gacc_pkg::BlockW-1-gacc_pkg::ByteW*b -: gacc_pkg::ByteW] ^ data_byte_i;
      end
    end
  end

  // One digit of the shift-and-add multiply.
  always_comb begin
    logic red;
    z_nxt = z_q;
    v_nxt = v_q;
    x_nxt = x_q;
    for (int i = 0; i < gacc_pkg::MulDigit; i++) begin
      if (x_nxt[gacc_pkg::BlockW-1]) begin
        z_nxt = z_nxt ^ v_nxt;
      end
      red   = v_nxt[0];
      v_nxt = v_nxt >> 1;
      if (red) begin
        v_nxt[gacc_pkg::BlockW-1 -: gacc_pkg::ByteW] =
          v_nxt[gacc_pkg::BlockW-1 -: gacc_pkg::ByteW] ^ gacc_pkg::RedConst;
      end
      x_nxt = x_nxt << 1;
    end
  end

  always_comb begin
    acc_d  = acc_q;
    fill_d = fill_q;
    x_d    = x_q;
    v_d    = v_q;
    z_d    = z_q;
    out_d  = out_q;
    if (cmd_i.clear) begin
      acc_d  = '0;
      fill_d = '0;
    end
    if (cmd_i.absorb) begin
      acc_d  = acc_abs;
      fill_d = fill_q + gacc_pkg::FillW'(1);
    end
    if (cmd_i.mul_start) begin
      x_d = cmd_i.absorb ? acc_abs : acc_q;
      v_d = {key_hi_q, key_lo_q};
      z_d = '0;
    end
    if (cmd_i.mul_step) begin
      x_d = x_nxt;
      v_d = v_nxt;
      z_d = z_nxt;
    end
    if (cmd_i.mul_last) begin
      acc_d  = z_nxt;
      fill_d = '0;
    end
    if (cmd_i.load_out) begin
      out_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      acc_q    <= '0;
      fill_q   <= '0;
    end else begin
      key_hi_q <= key_hi_d;
      key_lo_q <= key_lo_d;
      acc_q    <= acc_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    v_q   <= v_d;
    z_q   <= z_d;
    out_q <= out_d;
  end

  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.fill_last = (fill_q == gacc_pkg::FillW'(gacc_pkg::BlockBytes - 1));
  assign hash_high_o = out_q[gacc_pkg::BlockW-1 -: gacc_pkg::HalfW];
  assign hash_low_o  = out_q[gacc_pkg::HalfW-1:0];

endmodule

// File: rtl/core/gacc_ctrl.sv
// ----------------------------------------------------------------------------
// gacc_ctrl
// Controller: request decode, multiply sequencing and result handshake.
// ----------------------------------------------------------------------------
module gacc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gacc_pkg::cmd_e        in_cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gacc_pkg::dp_cmd_t     cmd_o,
  input  gacc_pkg::dp_status_t  status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [gacc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      emit_q, emit_d;
  logic                      out_valid_q, out_valid_d;
  logic                      in_fire, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) begin
          unique case (in_cmd_i)
            gacc_pkg::CMD_ABSORB: begin
              cmd_o.absorb = 1'b1;
              if (status_i.fill_last) begin
                cmd_o.mul_start = 1'b1;
                emit_d  = 1'b0;
                state_d = ST_MUL;
              end
            end
            gacc_pkg::CMD_PAD: begin
              if (!status_i.fill_zero) begin
                cmd_o.mul_start = 1'b1;
                emit_d  = 1'b0;
                state_d = ST_MUL;
              end
            end
            gacc_pkg::CMD_FINALIZE: begin
              if (!status_i.fill_zero) begin
                cmd_o.mul_start = 1'b1;
                emit_d  = 1'b1;
                state_d = ST_MUL;
              end else begin
                state_d = ST_EMIT;
              end
            end
            default: begin
              cmd_o.clear = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + gacc_pkg::CntW'(1);
        if (cnt_q == gacc_pkg::MulLast) begin
          cmd_o.mul_last = 1'b1;
          state_d = emit_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Load wins over a simultaneous take of the old result.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_mul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && cnt_q == gacc_pkg::MulLast) |=> (state_q != ST_MUL))
    else $error("multiply ran past its last digit");

  a_start_enters_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> (state_q == ST_MUL && cnt_q == '0))
    else $error("multiply start did not enter the multiply state at digit zero");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_start_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mul_start && cmd_o.mul_step))
    else $error("multiply start and step in the same cycle");

endmodule

// File: rtl/core/ghash_accumulator_core.sv
// ----------------------------------------------------------------------------
// ghash_accumulator_core
// GCM GHASH accumulator with a byte-wide request channel and a 128-bit result.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_if  : write key H; index REG_KEY_HIGH takes bytes 0..7, REG_KEY_LOW
//             bytes 8..15 (big-endian). Always ready; write only while idle.
//   in_if   : one request per handshake. Absorb XORs a byte into the block,
//             pad multiplies a partial block, finalize pads and emits,
//             restart clears the accumulator (the key is kept).
//   out_if  : one result per finalize, hash_high/hash_low big-endian.
// Timing:
//   An absorb that does not complete a block is simply accepted. A request that
//   starts a multiply is accepted and then runs the multiplier, which handles
//   8 accumulator bits per cycle; no request is taken until it ends. A
//   finalize loads its result in the emit state after the multiply, or right
//   after acceptance when nothing is left to pad, once the result register
//   is free; valid rises in the cycle after the load.
// Reset: clears key, accumulator, fill count and the result valid.
// Stall: the result sits in an output register; further requests are taken
//   while it waits, and only a finalize needing a free result register holds.
// ----------------------------------------------------------------------------
module ghash_accumulator_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  gacc_in_if.sink  in_if,
  gacc_out_if.source out_if,
  gacc_cfg_if.sink cfg_if
);

  gacc_pkg::dp_cmd_t    dp_cmd;
  gacc_pkg::dp_status_t dp_status;

  // Key registers take a write in every cycle.
  assign cfg_if.ready = 1'b1;

  gacc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_cmd_i    (in_if.cmd),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  gacc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .data_byte_i (in_if.data_byte),
    .cfg_we_i    (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .hash_high_o (out_if.hash_high),
    .hash_low_o  (out_if.hash_low)
  );

endmodule
